// ===== rtl/c8_pkg.sv =====
// Package with shared types, constants and request codes for the CHIP-8 core.
package c8_pkg;

  localparam int MEM_BYTES_D   = 4096;
  localparam int STACK_DEPTH_D = 16;
  localparam int SCREEN_W_D    = 64;
  localparam int SCREEN_H_D    = 32;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_EXEC   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] OP_CLS   = 16'h00E0;
  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [7:0]  F_ADDI   = 8'h1E;
  localparam logic [7:0]  F_BCD    = 8'h33;
  localparam logic [7:0]  F_STORE  = 8'h55;
  localparam logic [7:0]  F_LOAD   = 8'h65;
  localparam logic [15:0] LFSR_TAP = 16'hB400;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_pixels;
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic [1:0]  fault;
  } out_item_t;

  // Memory port request from the sequencer to the memory module.
  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

endpackage

// ===== rtl/c8_mem.sv =====
// Program memory with a clearing pass after reset and one registered read port.
module c8_mem (
  input  logic            clk,
  input  logic            rst_n,
  input  c8_pkg::mem_req_t req,
  output logic [7:0]      rdata,
  output logic            busy
);
  logic [7:0]  mem [c8_pkg::MEM_BYTES_D];
  logic [12:0] clr_r, clr_nxt;

  assign busy    = !clr_r[12];
  assign clr_nxt = busy ? clr_r + 13'd1 : clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[11:0]] <= 8'd0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end
endmodule

// ===== rtl/c8_frame.sv =====
// Framebuffer: 32 rows of 64 pixels, read and rewritten one row at a time.
module c8_frame (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [63:0] wdata,
  input  logic [4:0]  raddr,
  output logic [63:0] rdata
);
  logic [63:0] rows [c8_pkg::SCREEN_H_D];
  logic [31:0] valid_r, valid_nxt;

  // A row that is not valid reads as cleared.
  always_comb begin
    valid_nxt = valid_r;
    if (clr) valid_nxt = '0;
    else if (we) valid_nxt[waddr] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !clr) rows[waddr] <= wdata;
  end

  assign rdata = valid_r[raddr] ? rows[raddr] : 64'd0;
endmodule

// ===== rtl/chip8_instruction_core.sv =====
// Top level of the CHIP-8 core: sequencer, registers, stack and shared byte adder.
// A write or row read goes straight to S_OUT; an execute fetches both opcode bytes, then runs.
// FX55 stores a byte a step, FX65 reads then loads each, DXYN reads then XORs each row back.
// FX33 writes 3 digits. The next item waits for the result to go; all share one memory port.
// After reset a clearing pass zeroes memory and no item is taken meanwhile; reset
// also loads the program start of 512 and clears registers, stack depth and screen.
module chip8_instruction_core #(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  c8_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output c8_pkg::out_item_t out_data,
  input  logic              cfg_we,
  input  logic [11:0]       cfg_data
);
  localparam int SPW = $clog2(STACK_DEPTH);
  localparam int SDW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_F0 = 4'd1, S_F1 = 4'd2,
                         S_EXE = 4'd4, S_WALK = 4'd5, S_WAIT = 4'd6, S_SPR = 4'd7,
                         S_BCD = 4'd8, S_OUT = 4'd9;

  logic [3:0]  st_r, st_nxt;
  logic [11:0] pstart_r, pc_r, pc_nxt;
  logic [15:0] idx_r, idx_nxt, op_r, op_nxt, lfsr_r, lfsr_nxt;
  logic [7:0]  v_r [16];
  logic [7:0]  v_wd;
  logic [3:0]  v_wa;
  logic        v_we;
  logic [11:0] stk [STACK_DEPTH];
  logic [SDW-1:0] sp_r, sp_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  bcd_r, bcd_nxt;
  logic [1:0]  flt_r, flt_nxt;
  c8_pkg::out_item_t out_r, out_nxt;
  logic        ov_r, ov_nxt;
  logic        ex_r, ex_nxt;
  c8_pkg::mem_req_t mreq;
  logic [7:0]  mrd;
  logic        mbusy;
  logic        fclr, fwe;
  logic [4:0]  fwa, fra;
  logic [63:0] frd, fwd;
  logic [3:0]  ox, oy;
  logic [7:0]  vx, vy;
  // Shared byte adder used for ALU, immediate add, BCD steps and offsets.
  logic [7:0]  add_a, add_b, add_s;
  logic        acc;
  logic [63:0] spr;

  assign ox = op_r[11:8];
  assign oy = op_r[7:4];
  assign vx = v_r[ox];
  assign vy = v_r[oy];
  assign add_s = add_a + add_b;
  assign acc = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE) || mbusy || ov_r;

  c8_mem u_mem (.clk(clk), .rst_n(rst_n), .req(mreq), .rdata(mrd), .busy(mbusy));
  c8_frame u_frame (.clk(clk), .rst_n(rst_n), .clr(fclr), .we(fwe), .waddr(fwa),
                    .wdata(fwd), .raddr(fra), .rdata(frd));

  // Sprite byte rotated into the 64-pixel row at column vx.
  always_comb begin
    spr = {mrd, 56'd0};
    spr = (spr >> vx[5:0]) | (spr << (7'd64 - {1'b0, vx[5:0]}));
  end

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; idx_nxt = idx_r; op_nxt = op_r; lfsr_nxt = lfsr_r;
    sp_nxt = sp_r; cnt_nxt = cnt_r; bcd_nxt = bcd_r; flt_nxt = flt_r;
    out_nxt = out_r; ov_nxt = ov_r && out_stall;
    mreq = '{we: 1'b0, addr: pc_r, wdata: 8'd0};
    v_we = 1'b0; v_wa = ox; v_wd = 8'd0;
    fclr = 1'b0; fwe = 1'b0; fwa = 5'd0; fwd = frd; fra = in_data.address[4:0];
    add_a = vx; add_b = vy;
    unique case (st_r)
      S_IDLE: if (acc) begin
        out_nxt = '0;
        flt_nxt = c8_pkg::FAULT_NONE;
        unique case (in_data.req_type)
          c8_pkg::REQ_WRITE: begin
            mreq = '{we: 1'b1, addr: in_data.address, wdata: in_data.write_byte};
            st_nxt = S_OUT;
          end
          c8_pkg::REQ_EXEC: st_nxt = S_F0;
          c8_pkg::REQ_READ: begin
            out_nxt.row_pixels = frd;
            st_nxt = S_OUT;
          end
          default: st_nxt = S_OUT;
        endcase
      end
      S_F0: begin
        // The byte at pc was read at the accepting edge.
        op_nxt[15:8] = mrd;
        mreq.addr = pc_r + 12'd1;
        st_nxt = S_F1;
      end
      S_F1: begin
        op_nxt[7:0] = mrd;
        pc_nxt = pc_r + 12'd2;
        cnt_nxt = 4'd0;
        st_nxt = S_EXE;
      end
      S_EXE: begin
        st_nxt = S_OUT;
        unique case (op_r[15:12])
          4'h0: if (op_r == c8_pkg::OP_CLS) fclr = 1'b1;
                else if (op_r == c8_pkg::OP_RET) begin
                  if (sp_r == '0) flt_nxt = c8_pkg::FAULT_EMPTY;
                  else begin
                    sp_nxt = sp_r - 1'b1;
                    pc_nxt = stk[sp_nxt[SPW-1:0]];
                  end
                end
          4'h1: pc_nxt = op_r[11:0];
          4'h2: if (sp_r >= SDW'(STACK_DEPTH)) flt_nxt = c8_pkg::FAULT_FULL;
                else begin
                  sp_nxt = sp_r + 1'b1;
                  pc_nxt = op_r[11:0];
                end
          4'h3: if (vx == op_r[7:0]) pc_nxt = pc_r + 12'd2;
          4'h4: if (vx != op_r[7:0]) pc_nxt = pc_r + 12'd2;
          4'h5: if (vx == vy) pc_nxt = pc_r + 12'd2;
          4'h9: if (vx != vy) pc_nxt = pc_r + 12'd2;
          4'h6: begin v_we = 1'b1; v_wd = op_r[7:0]; end
          4'h7: begin add_b = op_r[7:0]; v_we = 1'b1; v_wd = add_s; end
          4'h8: begin
            v_we = 1'b1;
            case (op_r[3:0])
              4'h0: v_wd = vy;
              4'h1: v_wd = vx | vy;
              4'h2: v_wd = vx & vy;
              4'h3: v_wd = vx ^ vy;
              4'h4: v_wd = add_s;
              4'h5: begin add_b = ~vy + 8'd1; v_wd = add_s; end
              4'h7: begin add_a = ~vx + 8'd1; add_b = vy; v_wd = add_s; end
              4'h6: v_wd = {1'b0, vx[7:1]};
              4'hE: v_wd = {vx[6:0], 1'b0};
              default: v_we = 1'b0;
            endcase
          end
          4'hA: idx_nxt = {4'd0, op_r[11:0]};
          4'hB: pc_nxt = op_r[11:0] + {4'd0, v_r[0]};
          4'hC: begin
            lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? c8_pkg::LFSR_TAP : 16'd0);
            v_we = 1'b1; v_wd = lfsr_nxt[7:0] & op_r[7:0];
          end
          4'hD: if (op_r[3:0] != 4'd0) begin
            mreq.addr = idx_r[11:0];
            bcd_nxt = 8'd0;
            st_nxt = S_SPR;
          end
          4'hF: begin
            case (op_r[7:0])
              c8_pkg::F_ADDI: idx_nxt = idx_r + {8'd0, vx};
              c8_pkg::F_BCD: begin bcd_nxt = vx; st_nxt = S_BCD; end
              c8_pkg::F_STORE, c8_pkg::F_LOAD: begin
                mreq.addr = idx_r[11:0];
                st_nxt = S_WALK;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_WALK: begin
        // One byte per pass; loads see the read registered from the last cycle.
        mreq.addr = idx_r[11:0] + {8'd0, cnt_r};
        if (op_r[7:0] == c8_pkg::F_STORE) begin
          mreq.we = 1'b1; mreq.wdata = v_r[cnt_r];
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == ox) st_nxt = S_OUT;
        end else begin
          st_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        mreq.addr = idx_r[11:0] + {8'd0, cnt_r};
        v_we = 1'b1; v_wa = cnt_r; v_wd = mrd;
        cnt_nxt = cnt_r + 4'd1;
        st_nxt = (cnt_r == ox) ? S_OUT : S_WALK;
      end
      S_SPR: begin
        mreq.addr = idx_r[11:0] + {8'd0, cnt_r};
        add_a = vy; add_b = {4'd0, cnt_r};
        fra = add_s[4:0];
        if (bcd_r[0]) begin
          fwe = 1'b1; fwa = add_s[4:0]; fwd = frd ^ spr;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r + 4'd1 == op_r[3:0]) st_nxt = S_OUT;
          mreq.addr = idx_r[11:0] + {8'd0, cnt_nxt};
        end
        bcd_nxt = {7'd0, ~bcd_r[0]};
      end
      S_BCD: begin
        // Digits through the shared adder: hundreds by comparison, tens by repeated subtraction, units.
        mreq.we = 1'b1; mreq.addr = idx_r[11:0] + {8'd0, cnt_r};
        unique case (cnt_r[1:0])
          2'd0: begin mreq.wdata = {6'd0, (bcd_r >= 8'd200), 1'b0} | {7'd0,
                       (bcd_r >= 8'd100 && bcd_r < 8'd200)};
                 add_a = bcd_r;
                 add_b = (bcd_r >= 8'd200) ? 8'd56 : (bcd_r >= 8'd100) ? 8'd156 : 8'd0;
                 bcd_nxt = add_s; end
          2'd1: begin mreq.wdata = 8'd0;
                 if (bcd_r >= 8'd10) begin
                   mreq.we = 1'b0; add_a = bcd_r; add_b = 8'd246; bcd_nxt = add_s;
                   op_nxt[7:0] = op_r[7:0];
                   v_we = 1'b0;
                   // Tens digit counted in lfsr-free scratch: reuse out_r opcode.
                   out_nxt.executed_opcode = out_r.executed_opcode + 16'd1;
                 end else begin
                   mreq.wdata = out_r.executed_opcode[7:0];
                 end
               end
          default: begin mreq.wdata = bcd_r; st_nxt = S_OUT; end
        endcase
        if (mreq.we) cnt_nxt = cnt_r + 4'd1;
      end
      S_OUT: begin
        out_nxt.program_counter = pc_r;
        out_nxt.executed_opcode = ex_r ? op_r : 16'd0;
        out_nxt.fault = flt_r;
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_we) pc_nxt = cfg_data;
  end

  // Execute requests report the fetched opcode; tracked with a flag.
  always_comb begin
    ex_nxt = ex_r;
    if (st_r == S_IDLE && acc) ex_nxt = (in_data.req_type == c8_pkg::REQ_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; pstart_r <= c8_pkg::PC_RESET; pc_r <= c8_pkg::PC_RESET;
      idx_r <= '0; lfsr_r <= 16'd1; sp_r <= '0; ov_r <= 1'b0; ex_r <= 1'b0;
      for (int i = 0; i < 16; i++) v_r[i] <= 8'd0;
    end else begin
      st_r <= st_nxt; pc_r <= pc_nxt; idx_r <= idx_nxt; lfsr_r <= lfsr_nxt;
      sp_r <= sp_nxt; ov_r <= ov_nxt; ex_r <= ex_nxt;
      if (cfg_we) pstart_r <= cfg_data;
      if (v_we) v_r[v_wa] <= v_wd;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; cnt_r <= cnt_nxt; bcd_r <= bcd_nxt; flt_r <= flt_nxt;
    out_r <= out_nxt;
    if (st_r == S_EXE && op_r[15:12] == 4'h2 && sp_r < SDW'(STACK_DEPTH))
      stk[sp_r[SPW-1:0]] <= pc_r;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SDW'(STACK_DEPTH)) else $error("stack depth out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> $stable(out_data)) else $error("result changed");
  a_pstart: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) |-> pstart_r == $past(cfg_data)) else $error("program start lost");
endmodule

// ===== bench/tb_chip8_instruction_core.sv =====
// Self-checking testbench for the CHIP-8 instruction core with its own machine predictor.
module tb_chip8_instruction_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  c8_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  c8_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [11:0] cfg_data = '0;

  always #4 clk = ~clk;

  chip8_instruction_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Predicted machine state.
  logic [11:0] m_start, m_pc;
  logic [15:0] m_index, m_lfsr;
  logic [7:0]  m_v [16];
  logic [7:0]  m_mem [c8_pkg::MEM_BYTES_D];
  logic [11:0] m_stack [c8_pkg::STACK_DEPTH_D];
  int          m_depth;
  logic [63:0] m_rows [c8_pkg::SCREEN_H_D];

  c8_pkg::in_item_t  pending_items [$];
  c8_pkg::out_item_t expected_results [$];
  int errors = 0, results_seen = 0, n_exec = 0, n_faults = 0;
  int send_idle = 0, recv_idle = 0;
  logic feeding = 1'b0;
  logic taken = 1'b0;
  logic long_hold = 1'b0;

  function automatic void machine_reset();
    m_start = c8_pkg::PC_RESET; m_pc = c8_pkg::PC_RESET; m_index = '0; m_lfsr = 16'd1;
    m_depth = 0;
    foreach (m_v[i]) m_v[i] = '0;
    foreach (m_mem[i]) m_mem[i] = '0;
    foreach (m_stack[i]) m_stack[i] = '0;
    foreach (m_rows[i]) m_rows[i] = '0;
  endfunction

  function automatic logic [11:0] skip_pc(logic cond);
    return cond ? m_pc + 12'd2 : m_pc;
  endfunction

  function automatic logic [1:0] run_opcode(logic [15:0] op);
    logic [3:0] x, y, n;
    logic [7:0] nn, a, b, bits;
    logic [11:0] nnn;
    logic [1:0] flt;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
    a = m_v[x]; b = m_v[y]; flt = c8_pkg::FAULT_NONE;
    m_pc = m_pc + 12'd2;
    case (op[15:12])
      4'h0: begin
        if (op == c8_pkg::OP_CLS) begin
          foreach (m_rows[i]) m_rows[i] = '0;
        end else if (op == c8_pkg::OP_RET) begin
          if (m_depth == 0) flt = c8_pkg::FAULT_EMPTY;
          else begin
            m_depth--;
            m_pc = m_stack[m_depth];
          end
        end
      end
      4'h1: m_pc = nnn;
      4'h2: begin
        if (m_depth >= c8_pkg::STACK_DEPTH_D) flt = c8_pkg::FAULT_FULL;
        else begin
          m_stack[m_depth] = m_pc;
          m_depth++;
          m_pc = nnn;
        end
      end
      4'h3: m_pc = skip_pc(a == nn);
      4'h4: m_pc = skip_pc(a != nn);
      4'h5: m_pc = skip_pc(a == b);
      4'h6: m_v[x] = nn;
      4'h7: m_v[x] = a + nn;
      4'h8: begin
        case (n)
          4'h0: m_v[x] = b;
          4'h1: m_v[x] = a | b;
          4'h2: m_v[x] = a & b;
          4'h3: m_v[x] = a ^ b;
          4'h4: m_v[x] = a + b;
          4'h5: m_v[x] = a - b;
          4'h6: m_v[x] = a >> 1;
          4'h7: m_v[x] = b - a;
          4'hE: m_v[x] = a << 1;
          default: ;
        endcase
      end
      4'h9: m_pc = skip_pc(a != b);
      4'hA: m_index = {4'd0, nnn};
      4'hB: m_pc = nnn + {4'd0, m_v[0]};
      4'hC: begin
        m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ c8_pkg::LFSR_TAP) : (m_lfsr >> 1);
        m_v[x] = m_lfsr[7:0] & nn;
      end
      4'hD: begin
        for (int r = 0; r < n; r++) begin
          bits = m_mem[m_index[11:0] + 12'(r)];
          for (int c = 0; c < 8; c++)
            if (bits[7-c])
              m_rows[(int'(b) + r) % 32][63 - ((int'(a) + c) % 64)] ^= 1'b1;
        end
      end
      4'hF: begin
        case (nn)
          c8_pkg::F_ADDI: m_index = m_index + {8'd0, a};
          c8_pkg::F_BCD: begin
            m_mem[m_index[11:0]] = 8'(a / 100);
            m_mem[m_index[11:0] + 12'd1] = 8'((a / 10) % 10);
            m_mem[m_index[11:0] + 12'd2] = 8'(a % 10);
          end
          c8_pkg::F_STORE:
            for (int i = 0; i <= x; i++) m_mem[m_index[11:0] + 12'(i)] = m_v[i];
          c8_pkg::F_LOAD:
            for (int i = 0; i <= x; i++) m_v[i] = m_mem[m_index[11:0] + 12'(i)];
          default: ;
        endcase
      end
      default: ;
    endcase
    return flt;
  endfunction

  function automatic c8_pkg::out_item_t predict_result(c8_pkg::in_item_t it);
    c8_pkg::out_item_t r;
    logic [15:0] op;
    r = '0;
    case (it.req_type)
      c8_pkg::REQ_WRITE: m_mem[it.address] = it.write_byte;
      c8_pkg::REQ_EXEC: begin
        op = {m_mem[m_pc], m_mem[m_pc + 12'd1]};
        r.executed_opcode = op;
        r.fault = run_opcode(op);
        n_exec++;
        if (r.fault != c8_pkg::FAULT_NONE) n_faults++;
      end
      c8_pkg::REQ_READ: r.row_pixels = m_rows[it.address[4:0]];
      default: ;
    endcase
    r.program_counter = m_pc;
    return r;
  endfunction

  // Driver: an item taken at the rising edge is predicted and dropped from the queue there.
  always @(posedge clk) begin
    taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(predict_result(in_data));
      void'(pending_items.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!in_valid || taken) begin
      if (feeding && pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else
        in_valid <= 1'b0;
    end
    out_stall <= long_hold || ($urandom_range(99) < recv_idle);
  end

  // Monitor.
  always @(posedge clk) begin
    c8_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data.row_pixels !== e.row_pixels ||
            out_data.program_counter !== e.program_counter ||
            out_data.executed_opcode !== e.executed_opcode ||
            out_data.fault !== e.fault) begin
          errors++;
          $display("%0t: mismatch expected rows %h pc %h op %h fault %0d", $time,
                   e.row_pixels, e.program_counter, e.executed_opcode, e.fault);
          $display("%0t:          actual   rows %h pc %h op %h fault %0d", $time,
                   out_data.row_pixels, out_data.program_counter,
                   out_data.executed_opcode, out_data.fault);
        end
      end
    end
  end

  task automatic add_item(logic [1:0] kind, logic [11:0] addr, logic [7:0] data);
    c8_pkg::in_item_t it;
    it.req_type = kind; it.address = addr; it.write_byte = data;
    pending_items.push_back(it);
  endtask

  task automatic add_op(logic [11:0] addr, logic [15:0] op);
    add_item(c8_pkg::REQ_WRITE, addr, op[15:8]);
    add_item(c8_pkg::REQ_WRITE, addr + 12'd1, op[7:0]);
  endtask

  // Waits until every item has gone through and the core has settled.
  task automatic drain();
    feeding = 1'b1;
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    feeding = 1'b0;
    repeat (60) @(posedge clk);
  endtask

  task automatic set_start(logic [11:0] value);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    m_start = value; m_pc = value;
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(9))
      0: op = (op[0]) ? c8_pkg::OP_RET : c8_pkg::OP_CLS;
      1: op[15:12] = 4'h2;
      2: op = {4'hF, op[11:8], (op[1] ? c8_pkg::F_STORE : c8_pkg::F_LOAD)};
      3: op = {4'hF, op[11:8], (op[1] ? c8_pkg::F_BCD : c8_pkg::F_ADDI)};
      4: op[15:12] = 4'h8;
      5: op[15:12] = 4'hD;
      default: ;
    endcase
    return op;
  endfunction

  // Random phase: a program of random opcodes is written then executed, with reads, writes and unused codes mixed in.
  task automatic random_block(int count);
    logic [11:0] base;
    int done;
    done = 0;
    base = m_start;
    while (done < count) begin
      for (int i = 0; i < 16; i++) begin
        add_op(base + 12'(2 * i), random_opcode());
        done += 2;
      end
      for (int i = 0; i < 24; i++) begin
        case ($urandom_range(9))
          0: add_item(c8_pkg::REQ_READ, 12'($urandom), 8'($urandom));
          1: add_item(c8_pkg::REQ_UNUSED, 12'($urandom), 8'($urandom));
          2: add_item(c8_pkg::REQ_WRITE, 12'($urandom), 8'($urandom));
          default: add_item(c8_pkg::REQ_EXEC, 12'($urandom), 8'($urandom));
        endcase
        done++;
      end
      // Return to the block start so the program keeps running known code.
      add_op(m_start, {4'h1, base});
      done += 2;
    end
  endtask

  initial begin
    machine_reset();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    // Directed part: drawing, stack faults, arithmetic wrap and odd request codes.
    add_op(12'h200, 16'h60FF);
    add_op(12'h202, 16'h7001);
    add_op(12'h204, 16'h613E);
    add_op(12'h206, 16'hA300);
    add_op(12'h208, 16'hD01F);
    add_op(12'h20A, 16'h00EE);
    add_op(12'h20C, 16'hC0FF);
    add_op(12'h20E, 16'h2FFE);
    add_item(c8_pkg::REQ_WRITE, 12'h300, 8'hFF);
    add_item(c8_pkg::REQ_WRITE, 12'hFFF, 8'hFF);
    for (int i = 0; i < 8; i++) add_item(c8_pkg::REQ_EXEC, 12'h000, 8'h00);
    add_item(c8_pkg::REQ_READ, 12'hFFF, 8'hFF);
    add_item(c8_pkg::REQ_READ, 12'h01E, 8'h00);
    add_item(c8_pkg::REQ_UNUSED, 12'hFFF, 8'hFF);
    drain();
    // A call loop fills the stack until it faults.
    set_start(12'hFFE);
    add_op(12'hFFE, 16'h2FFE);
    for (int i = 0; i < 18; i++) add_item(c8_pkg::REQ_EXEC, '0, '0);
    drain();
    send_idle = 21; recv_idle = 80;
    set_start(12'h000);
    random_block(550);
    drain();
    send_idle = 80; recv_idle = 21;
    set_start(12'($urandom_range(4000)) & 12'hFE0);
    random_block(550);
    drain();
    send_idle = 0; recv_idle = 0;
    set_start(12'h200);
    random_block(550);
    // The receiver holds off for a long stretch while the sender keeps offering items.
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end
    join_none
    drain();
    $display("Ran %0d results, %0d executes, %0d stack faults over four start addresses.",
             results_seen, n_exec, n_faults);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/c8_pkg.sv
rtl/c8_mem.sv
rtl/c8_frame.sv
rtl/chip8_instruction_core.sv
bench/tb_chip8_instruction_core.sv
